FILE: src/assert_macros.svh
// Assertion macros used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LFFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LFFP_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define LFFP_ASSERT(lbl, clk, rst_n, prop, msg)

`define LFFP_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: src/lffp_pkg.sv
// Types and constants of the laser frame file parser.
package lffp_pkg;

    localparam int unsigned POS_W = 5;

    // Header byte offsets that carry data, and the last header offset.
    localparam logic [POS_W-1:0] HDR_FORMAT   = 5'd7;
    localparam logic [POS_W-1:0] HDR_COUNT_HI = 5'd24;
    localparam logic [POS_W-1:0] HDR_COUNT_LO = 5'd25;
    localparam logic [POS_W-1:0] HDR_FRAME_HI = 5'd26;
    localparam logic [POS_W-1:0] HDR_FRAME_LO = 5'd27;
    localparam logic [POS_W-1:0] HDR_HEAD     = 5'd30;
    localparam logic [POS_W-1:0] HDR_LAST     = 5'd31;

    // Offset of the status byte in a point record, and the largest record offset.
    localparam logic [POS_W-1:0] STATUS_POS_3D = 5'd6;
    localparam logic [POS_W-1:0] STATUS_POS_2D = 5'd4;
    localparam logic [POS_W-1:0] MAX_REC_POS   = 5'd9;

    // Format codes with a layout of their own; every other code is 2D true color.
    localparam logic [7:0] FMT_3D_INDEXED = 8'd0;
    localparam logic [7:0] FMT_2D_INDEXED = 8'd1;
    localparam logic [7:0] FMT_3D_TRUE    = 8'd4;

    typedef struct packed {
        logic              valid;
        logic [7:0]        data;
    } byte_stage_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [7:0]         point_status;
        logic [7:0]         color_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [15:0] frame_number;
        logic [7:0]         scanner_head;
        logic [7:0]         format_code;
        logic               last_in_frame;
    } point_t;

endpackage

FILE: src/lffp_byte_if.sv
// Byte request channel into the parser.
interface lffp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;

    modport source (output valid, output file_byte, input ready);
    modport sink (input valid, input file_byte, output ready);
endinterface

FILE: src/lffp_point_if.sv
// Point request channel out of the parser.
interface lffp_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [7:0]         point_status;
    logic [7:0]         color_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [15:0] frame_number;
    logic [7:0]         scanner_head;
    logic [7:0]         format_code;
    logic               last_in_frame;

    modport source (
        output valid, input ready,
        output x, output y, output z, output point_status, output color_index,
        output red, output green, output blue, output frame_number,
        output scanner_head, output format_code, output last_in_frame
    );
    modport sink (
        input valid, output ready,
        input x, input y, input z, input point_status, input color_index,
        input red, input green, input blue, input frame_number,
        input scanner_head, input format_code, input last_in_frame
    );
endinterface

FILE: src/lffp_in_reg.sv
// Input register that holds one file byte until the parser takes it.
module lffp_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    lffp_byte_if.sink            bytes,
    input  logic                 advance,
    output lffp_pkg::byte_stage_t stage
);
    import lffp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    assign bytes.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (bytes.ready)
        begin
            valid_next = bytes.valid;
            if (bytes.valid)
            begin
                data_next = bytes.file_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;
endmodule

FILE: src/lffp_core.sv
// Parser state and the per-byte header and point record decode.
`include "assert_macros.svh"

module lffp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       file_byte,
    output logic             emit,
    output lffp_pkg::point_t point
);
    import lffp_pkg::*;

    logic             in_points_reg, in_points_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       format_reg, format_next;
    logic [15:0]      remaining_reg, remaining_next;
    logic [15:0]      frame_num_reg, frame_num_next;
    logic [7:0]       head_reg, head_next;
    logic [7:0]       pend_reg, pend_next;
    logic [15:0]      x_reg, x_next;
    logic [15:0]      y_reg, y_next;
    logic [15:0]      z_reg, z_next;
    logic [7:0]       status_reg, status_next;
    logic [7:0]       blue_reg, blue_next;

    logic             is3d;
    logic             indexed;
    logic [POS_W-1:0] status_pos;
    logic [15:0]      word;
    logic [15:0]      remaining_dec;
    logic             done;
    logic [7:0]       cidx;
    logic [7:0]       red;
    logic             count_pos;
    logic             rec_pos_ok;
    logic             last_emit;
    logic             enter_points;

    assign is3d       = (format_reg == FMT_3D_INDEXED) || (format_reg == FMT_3D_TRUE);
    assign indexed    = (format_reg == FMT_3D_INDEXED) || (format_reg == FMT_2D_INDEXED);
    assign status_pos = is3d ? STATUS_POS_3D : STATUS_POS_2D;
    assign word       = {pend_reg, file_byte};
    assign remaining_dec = remaining_reg - 16'd1;
    assign count_pos  = (remaining_reg != 16'd0) && !remaining_reg[15];

    always_comb
    begin
        in_points_next = in_points_reg;
        pos_next       = pos_reg;
        format_next    = format_reg;
        remaining_next = remaining_reg;
        frame_num_next = frame_num_reg;
        head_next      = head_reg;
        pend_next      = pend_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        status_next    = status_reg;
        blue_next      = blue_reg;
        done           = 1'b0;
        cidx           = 8'd0;
        red            = 8'd0;

        if (!in_points_reg)
        begin
            unique case (pos_reg)
                HDR_FORMAT:   format_next    = file_byte;
                HDR_COUNT_HI: pend_next      = file_byte;
                HDR_COUNT_LO: remaining_next = word;
                HDR_FRAME_HI: pend_next      = file_byte;
                HDR_FRAME_LO: frame_num_next = word;
                HDR_HEAD:     head_next      = file_byte;
                default:      ;
            endcase
            if (pos_reg == HDR_LAST)
            begin
                pos_next = '0;
                // The count is complete by now; zero or negative means no points.
                in_points_next = count_pos;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
        else
        begin
            priority if (pos_reg < status_pos)
            begin
                if (!pos_reg[0])
                begin
                    pend_next = file_byte;
                end
                else
                begin
                    unique case (pos_reg[2:1])
                        2'd0:    x_next = word;
                        2'd1:    y_next = word;
                        default: z_next = word;
                    endcase
                end
            end
            else if (pos_reg == status_pos)
            begin
                status_next = file_byte;
                if (!is3d)
                begin
                    z_next = 16'd0;
                end
            end
            else if (indexed)
            begin
                cidx = file_byte;
                done = 1'b1;
            end
            else if (pos_reg == status_pos + 5'd1)
            begin
                blue_next = file_byte;
            end
            else if (pos_reg == status_pos + 5'd2)
            begin
                // The green byte waits in the word buffer until red arrives.
                pend_next = file_byte;
            end
            else
            begin
                red  = file_byte;
                done = 1'b1;
            end

            if (done)
            begin
                pos_next       = '0;
                remaining_next = remaining_dec;
                if (remaining_dec == 16'd0)
                begin
                    in_points_next = 1'b0;
                end
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_comb
    begin
        emit                = take && done;
        point.x             = x_reg;
        point.y             = y_reg;
        point.z             = is3d ? z_reg : 16'd0;
        point.point_status  = status_reg;
        point.color_index   = cidx;
        point.red           = red;
        point.green         = indexed ? 8'd0 : pend_reg;
        point.blue          = indexed ? 8'd0 : blue_reg;
        point.frame_number  = frame_num_reg;
        point.scanner_head  = head_reg;
        point.format_code   = format_reg;
        point.last_in_frame = (remaining_dec == 16'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_points_reg <= 1'b0;
            pos_reg       <= '0;
            format_reg    <= 8'd0;
            remaining_reg <= 16'd0;
            frame_num_reg <= 16'd0;
            head_reg      <= 8'd0;
            pend_reg      <= 8'd0;
            x_reg         <= 16'd0;
            y_reg         <= 16'd0;
            z_reg         <= 16'd0;
            status_reg    <= 8'd0;
            blue_reg      <= 8'd0;
        end
        else if (take)
        begin
            in_points_reg <= in_points_next;
            pos_reg       <= pos_next;
            format_reg    <= format_next;
            remaining_reg <= remaining_next;
            frame_num_reg <= frame_num_next;
            head_reg      <= head_next;
            pend_reg      <= pend_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            status_reg    <= status_next;
            blue_reg      <= blue_next;
        end
    end

    assign rec_pos_ok   = (pos_reg <= MAX_REC_POS);
    assign last_emit    = emit && point.last_in_frame;
    assign enter_points = take && !in_points_reg && (pos_reg == HDR_LAST) && count_pos;

    `LFFP_ASSERT(a_pos_range, clk, rst_n, in_points_reg |-> rec_pos_ok, "position out of range")
    `LFFP_ASSERT(a_last_exit, clk, rst_n, last_emit |=> !in_points_reg, "points after last")
    `LFFP_ASSERT(a_enter, clk, rst_n, enter_points |=> in_points_reg, "no points after count")
    `LFFP_NEVER(a_emit_in_header, clk, rst_n, emit && !in_points_reg, "point emitted in header")
endmodule

FILE: src/lffp_out_reg.sv
// Result register that presents one parsed point until it is taken.
module lffp_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lffp_pkg::point_t point,
    output logic             open,
    lffp_point_if.source     points
);
    import lffp_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    point_t point_reg;

    assign open = !valid_reg || points.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (points.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            point_reg <= point;
        end
    end

    assign points.valid         = valid_reg;
    assign points.x             = point_reg.x;
    assign points.y             = point_reg.y;
    assign points.z             = point_reg.z;
    assign points.point_status  = point_reg.point_status;
    assign points.color_index   = point_reg.color_index;
    assign points.red           = point_reg.red;
    assign points.green         = point_reg.green;
    assign points.blue          = point_reg.blue;
    assign points.frame_number  = point_reg.frame_number;
    assign points.scanner_head  = point_reg.scanner_head;
    assign points.format_code   = point_reg.format_code;
    assign points.last_in_frame = point_reg.last_in_frame;
endmodule

FILE: src/laser_frame_file_parser.sv
// Top level of the laser frame file parser.
// Takes a laser frame file one byte per request and returns one request per
// complete point record, with the header's frame number, scanner head and
// format code attached and the frame's final point flagged. Each byte passes
// an input register, a combinational decode and a result register, so the
// block accepts a byte in every clock cycle while the result side keeps up; a
// point is loaded into the result register when the last byte of its record
// is decoded out of the input register. While a point waits untaken in the
// result register, at most one more byte is accepted and then the input
// stalls. Headers, including those with a zero or negative point count,
// produce no requests.
module laser_frame_file_parser (
    input  logic          clk,
    input  logic          rst_n,
    lffp_byte_if.sink     bytes,
    lffp_point_if.source  points
);
    import lffp_pkg::*;

    byte_stage_t stage;
    point_t      point;
    logic        advance;
    logic        emit;
    logic        out_open;

    assign advance = stage.valid && out_open;

    lffp_in_reg u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .advance (advance),
        .stage   (stage)
    );

    lffp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (advance),
        .file_byte (stage.data),
        .emit      (emit),
        .point     (point)
    );

    lffp_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (emit),
        .point  (point),
        .open   (out_open),
        .points (points)
    );
endmodule
